@@ sv/lzsd_pkg.sv @@
`timescale 1ns / 1ps

package lzsd_pkg;

  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = 12;
  localparam int MATCH_MIN  = 3;
  localparam int MAX_MATCH  = 18;
  localparam logic [HIST_AW-1:0] START_POS = 12'(HIST_DEPTH - MAX_MATCH);
  localparam logic [24:0] COUNT_MAX = 25'h1FFFFFF;
  localparam logic [7:0]  FILL_BYTE = 8'hFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } comp_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } dec_item_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_TOKEN,
    PH_PAIR2
  } phase_t;

  typedef enum logic [2:0] {
    K_HEADER,
    K_FLAG,
    K_LIT,
    K_PAIR1,
    K_PAIR2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_READ,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic accept;
    logic produce_lit;
    logic read;
    logic produce_copy;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  in_end;
    logic  end_flag;
    logic  emit;
    logic  slot_free;
    logic  copy_last;
  } ctrl_stat_t;

endpackage

@@ sv/lzsd_ram.sv @@
`timescale 1ns / 1ps

module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/lzsd_ctrl.sv @@
`timescale 1ns / 1ps

module lzsd_ctrl
  import lzsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       comp_valid,
  output logic       comp_stall,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    comp_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (comp_valid) begin
          cmd.accept = 1'b1;
          case (stat.kind)
            K_LIT:   state_next = ST_LIT;
            K_PAIR2: state_next = ST_READ;
            default: cmd.clear = stat.in_end;
          endcase
        end
      end
      ST_LIT: begin
        // wait for the output slot only if this byte is emitted
        if (!stat.emit || stat.slot_free) begin
          cmd.produce_lit = 1'b1;
          cmd.clear       = stat.end_flag;
          state_next      = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (!stat.emit || stat.slot_free) begin
          cmd.produce_copy = 1'b1;
          if (stat.copy_last) begin
            cmd.clear  = stat.end_flag;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ sv/lzsd_dp.sv @@
`timescale 1ns / 1ps

module lzsd_dp
  import lzsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  comp_item_t comp_item,
  output logic       dec_valid,
  input  logic       dec_stall,
  output dec_item_t  dec_item,
  input  ctrl_cmd_t  cmd,
  output ctrl_stat_t stat
);

  logic [HIST_AW-1:0] write_pos;
  logic [HIST_AW:0]   fill;
  logic [7:0]         flag_bits;
  logic [3:0]         tokens_left;
  phase_t             phase;
  logic [1:0]         header_count;
  logic [7:0]         pair_high;
  logic [23:0]        target_size;
  logic [24:0]        produced_count;
  logic               end_flag;
  logic [7:0]         lit_byte;
  logic [HIST_AW-1:0] copy_off;
  logic [4:0]         copy_left;
  logic               rd_ok;
  logic [7:0]         rd_data;
  logic               out_valid;
  dec_item_t          out_item;

  kind_t              kind;
  logic               produce;
  logic [7:0]         prod_byte;
  logic               emit;
  logic [25:0]        count_inc;
  logic               next_emit;
  logic [HIST_AW-1:0] rd_addr;

  always_comb begin
    case (phase)
      PH_HEADER: kind = K_HEADER;
      PH_PAIR2:  kind = K_PAIR2;
      default: begin
        if (tokens_left == 4'd0) begin
          kind = K_FLAG;
        end else if (flag_bits[7]) begin
          kind = K_PAIR1;
        end else begin
          kind = K_LIT;
        end
      end
    endcase
  end

  assign produce   = cmd.produce_lit || cmd.produce_copy;
  assign prod_byte = cmd.produce_lit ? lit_byte : (rd_ok ? rd_data : FILL_BYTE);
  assign emit      = produced_count < {1'b0, target_size};
  assign count_inc = {1'b0, produced_count} + 26'd1;
  assign next_emit = count_inc < {2'b00, target_size};
  assign rd_addr   = write_pos - copy_off - 12'd1;

  assign stat.kind      = kind;
  assign stat.in_end    = comp_item.stream_end;
  assign stat.end_flag  = end_flag;
  assign stat.emit      = emit;
  assign stat.slot_free = !out_valid || !dec_stall;
  assign stat.copy_last = (copy_left == 5'd1);

  lzsd_ram #(
    .WIDTH(8),
    .DEPTH(HIST_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (produce),
    .waddr(write_pos),
    .wdata(prod_byte),
    .re   (cmd.read),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos      <= START_POS;
      fill           <= '0;
      flag_bits      <= '0;
      tokens_left    <= '0;
      phase          <= PH_HEADER;
      header_count   <= '0;
      pair_high      <= '0;
      target_size    <= '0;
      produced_count <= '0;
      end_flag       <= 1'b0;
      copy_left      <= '0;
      rd_ok          <= 1'b0;
    end else begin
      if (cmd.accept) begin
        end_flag <= comp_item.stream_end;
        case (kind)
          K_HEADER: begin
            case (header_count)
              2'd1: target_size[7:0]   <= comp_item.in_byte;
              2'd2: target_size[15:8]  <= comp_item.in_byte;
              2'd3: target_size[23:16] <= comp_item.in_byte;
              default: ;
            endcase
            header_count <= header_count + 2'd1;
            if (header_count == 2'd3) begin
              phase <= PH_TOKEN;
            end
          end
          K_FLAG: begin
            flag_bits   <= comp_item.in_byte;
            tokens_left <= 4'd8;
          end
          K_LIT: begin
            flag_bits   <= {flag_bits[6:0], 1'b0};
            tokens_left <= tokens_left - 4'd1;
          end
          K_PAIR1: begin
            flag_bits   <= {flag_bits[6:0], 1'b0};
            tokens_left <= tokens_left - 4'd1;
            pair_high   <= comp_item.in_byte;
            phase       <= PH_PAIR2;
          end
          K_PAIR2: begin
            copy_left <= {1'b0, pair_high[7:4]} + 5'(MATCH_MIN);
            phase     <= PH_TOKEN;
          end
          default: ;
        endcase
      end
      // history entries older than the fill count read as the fill byte
      if (cmd.read) begin
        rd_ok <= ({1'b0, copy_off} < fill);
      end
      if (produce) begin
        write_pos <= write_pos + 12'd1;
        if (fill != 13'(HIST_DEPTH)) begin
          fill <= fill + 13'd1;
        end
        if (produced_count != COUNT_MAX) begin
          produced_count <= count_inc[24:0];
        end
      end
      if (cmd.produce_copy) begin
        copy_left <= copy_left - 5'd1;
      end
      if (cmd.clear) begin
        write_pos      <= START_POS;
        fill           <= '0;
        flag_bits      <= '0;
        tokens_left    <= '0;
        phase          <= PH_HEADER;
        header_count   <= '0;
        pair_high      <= '0;
        target_size    <= '0;
        produced_count <= '0;
        end_flag       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lit_byte <= comp_item.in_byte;
      if (kind == K_PAIR2) begin
        copy_off <= {pair_high[3:0], comp_item.in_byte};
      end
    end
  end

  // output register: hold while stalled, load a produced item when emitted
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (produce && emit) begin
      out_valid <= 1'b1;
    end else if (!dec_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce && emit) begin
      out_item.out_byte <= prod_byte;
      out_item.run_last <= cmd.produce_lit || (copy_left == 5'd1) || !next_emit;
    end
  end

  assign dec_valid = out_valid;
  assign dec_item  = out_item;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 13'(HIST_DEPTH))
    else $error("history fill count exceeds depth");

  a_clear_state: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (write_pos == START_POS) && (fill == '0) && (phase == PH_HEADER))
    else $error("clear did not restore stream start state");

  a_copy_len: assert property (@(posedge clk) disable iff (rst)
    cmd.produce_copy |-> (copy_left != 5'd0))
    else $error("copy step with no bytes left");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (produce && emit) |-> (!out_valid || !dec_stall))
    else $error("output item overwritten while stalled");

  a_header_tokens: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEADER) |-> (tokens_left == 4'd0))
    else $error("tokens pending during header");

endmodule

@@ sv/lz77_stream_decompressor_core.sv @@
`timescale 1ns / 1ps

// LZ77 stream decompressor (type 0x10 streams). Feed the compressed stream one
// byte per item, header included, and mark its last byte with stream_end; all
// state returns to stream start after that byte. Header, flag and first pair
// bytes produce nothing. A literal is accepted and then written; in a pair
// (length 3..18) each copied byte is one read of the 4096-byte history RAM,
// whose registered read port sets the pace, then one write. A stalled output
// holds the writes of delivered bytes. Bytes past the header size go into
// the history but are not delivered; run_last marks the last delivered byte
// of an input item. No clearing pass runs after reset or stream end: a fill
// count makes untouched history read as 0xFF.
module lz77_stream_decompressor_core
  import lzsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       comp_valid,
  output logic       comp_stall,
  input  comp_item_t comp_item,
  output logic       dec_valid,
  input  logic       dec_stall,
  output dec_item_t  dec_item
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  lzsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .comp_valid(comp_valid),
    .comp_stall(comp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lzsd_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .comp_item(comp_item),
    .dec_valid(dec_valid),
    .dec_stall(dec_stall),
    .dec_item (dec_item),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
